// ===== hdl/anac_pkg.sv =====
`timescale 1ns / 1ps
package anac_pkg;

  localparam int HISTORY_DEPTH_DEF = 5;
  localparam logic [15:0] CHECK_INTERVAL_RST = 16'd500;
  localparam logic [32:0] REST_TOL_RST = 33'd26896;
  localparam int FILTER_REACH = 20;

  // configuration register indexes
  localparam logic CFG_CHECK_INTERVAL = 1'b0;
  localparam logic CFG_REST_TOL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DSX, ST_DSY, ST_SLOT, ST_REST, ST_ATX, ST_ATY,
    ST_CX, ST_CY, ST_SQ, ST_MOVE, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    DV_SX, DV_SY, DV_TX, DV_TY, DV_AX, DV_AY
  } div_sel_t;

  typedef struct packed {
    logic sample_ld;
    logic report_ld;
    logic div_start;
    div_sel_t div_sel;
    logic slot_upd;
    logic rest_step;
    logic k_clr;
    logic avg_next;
    logic sq_ld;
    logic move;
    logic out_ld;
  } ctl_t;

  typedef struct packed {
    logic cnt_zero;
    logic div_busy;
    logic div_done;
    logic advance;
    logic k_last;
    logic slot_empty;
    logic rest_ok;
    logic out_free;
  } sts_t;

  localparam logic signed [5:0] NOISE [0:40] = '{
    -6'sd18, -6'sd16, -6'sd14, -6'sd13, -6'sd11, -6'sd10, -6'sd8, -6'sd7,
    -6'sd6, -6'sd5, -6'sd4, -6'sd3, -6'sd2, -6'sd2, -6'sd1, -6'sd1,
    6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0, 6'sd0,
    6'sd1, 6'sd1, 6'sd2, 6'sd2, 6'sd3, 6'sd4, 6'sd5, 6'sd6, 6'sd7,
    6'sd8, 6'sd10, 6'sd11, 6'sd13, 6'sd14, 6'sd16, 6'sd18
  };

  // truncate by 4, noise table near zero, truncate by 64, clamp
  function automatic logic signed [8:0] to_report(input logic signed [31:0] avg);
    logic signed [31:0] v;
    logic signed [31:0] w;
    logic [5:0] ti;
    v = (avg + (avg[31] ? 32'sd3 : 32'sd0)) >>> 2;
    if (v >= -32'(FILTER_REACH) && v <= 32'(FILTER_REACH)) begin
      ti = 6'(v + 32'(FILTER_REACH));
      v = 32'(NOISE[ti]);
    end
    w = (v + (v[31] ? 32'sd63 : 32'sd0)) >>> 6;
    if (w > 32'sd255) return 9'sd255;
    else if (w < -32'sd255) return -9'sd255;
    else return w[8:0];
  endfunction

endpackage

// ===== hdl/accel_nudge_autocenter.sv =====
`timescale 1ns / 1ps
// Sample items are taken while idle. A report stalls the input until its result is
// loaded, after two divisions (x, then y) on the shared divider; a report with no
// samples skips them. A history advance adds a square and a move step; a wrap adds
// a rest check over all D slots and, when resting, up to 2*D+2 divisions
// (D = HISTORY_DEPTH). The result waits in an output register while new items are
// taken. Sync active-low reset clears control state, sums, history and out_valid.
module accel_nudge_autocenter #(
  parameter int HISTORY_DEPTH = anac_pkg::HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [15:0] in_sample_x,
  input  logic signed [15:0] in_sample_y,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [8:0]  out_report_x,
  output logic signed [8:0]  out_report_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [32:0]        cfg_data
);

  anac_pkg::ctl_t ctl;
  anac_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  anac_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(in_cmd),
    .in_stall(in_stall), .sts(sts), .ctl(ctl)
  );

  anac_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_sample_x(in_sample_x), .in_sample_y(in_sample_y),
    .in_now_ms(in_now_ms), .ctl(ctl), .sts(sts), .out_stall(out_stall),
    .out_valid(out_valid), .out_report_x(out_report_x), .out_report_y(out_report_y)
  );

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_ld |-> sts.out_free)
    else $error("result loaded over a held item");

  a_report_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_cmd) |=> (in_stall && !ctl.out_ld))
    else $error("report finished too early");

endmodule

// ===== hdl/anac_div.sv =====
`timescale 1ns / 1ps
module anac_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [15:0]        divisor,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic        busy_r, done_r, neg_r;
  logic [4:0]  cnt_r;
  logic [15:0] rem_r, d_r;
  logic [31:0] q_r;
  logic [16:0] sh;

  assign sh = {rem_r, q_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        d_r    <= divisor;
        neg_r  <= dividend[31];
        q_r    <= dividend[31] ? 32'(-dividend) : 32'(dividend);
      end else if (busy_r) begin
        // one restoring step per cycle
        if (sh >= {1'b0, d_r}) begin
          rem_r <= 16'(sh - {1'b0, d_r});
          q_r   <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= sh[15:0];
          q_r   <= {q_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

// ===== hdl/anac_ctrl.sv =====
`timescale 1ns / 1ps
module anac_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_cmd,
  output logic            in_stall,
  input  anac_pkg::sts_t  sts,
  output anac_pkg::ctl_t  ctl
);

  anac_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= anac_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      anac_pkg::ST_IDLE:
        if (in_valid && in_cmd)
          state_nxt = sts.cnt_zero ? anac_pkg::ST_SLOT : anac_pkg::ST_DSX;
      anac_pkg::ST_DSX: if (sts.div_done) state_nxt = anac_pkg::ST_DSY;
      anac_pkg::ST_DSY: if (sts.div_done) state_nxt = anac_pkg::ST_SLOT;
      anac_pkg::ST_SLOT: begin
        if (!sts.advance) state_nxt = anac_pkg::ST_OUT;
        else if (sts.k_last) state_nxt = anac_pkg::ST_REST;
        else state_nxt = anac_pkg::ST_SQ;
      end
      anac_pkg::ST_REST:
        if (sts.k_last) state_nxt = sts.rest_ok ? anac_pkg::ST_ATX : anac_pkg::ST_SQ;
      anac_pkg::ST_ATX: begin
        if (sts.slot_empty) begin
          if (sts.k_last) state_nxt = anac_pkg::ST_CX;
        end else if (sts.div_done) state_nxt = anac_pkg::ST_ATY;
      end
      anac_pkg::ST_ATY:
        if (sts.div_done) state_nxt = sts.k_last ? anac_pkg::ST_CX : anac_pkg::ST_ATX;
      anac_pkg::ST_CX: if (sts.div_done) state_nxt = anac_pkg::ST_CY;
      anac_pkg::ST_CY: if (sts.div_done) state_nxt = anac_pkg::ST_SQ;
      anac_pkg::ST_SQ: state_nxt = anac_pkg::ST_MOVE;
      anac_pkg::ST_MOVE: state_nxt = anac_pkg::ST_OUT;
      anac_pkg::ST_OUT: if (sts.out_free) state_nxt = anac_pkg::ST_IDLE;
      default: state_nxt = anac_pkg::ST_IDLE;
    endcase
  end

  logic div_go;
  assign div_go = !sts.div_busy && !sts.div_done;

  always_comb begin
    ctl = '0;
    ctl.div_sel = anac_pkg::DV_SX;
    in_stall = (state_r != anac_pkg::ST_IDLE);
    unique case (state_r)
      anac_pkg::ST_IDLE: begin
        ctl.sample_ld = in_valid && !in_cmd;
        ctl.report_ld = in_valid && in_cmd;
      end
      anac_pkg::ST_DSX: ctl.div_start = div_go;
      anac_pkg::ST_DSY: begin
        ctl.div_sel = anac_pkg::DV_SY;
        ctl.div_start = div_go;
      end
      anac_pkg::ST_SLOT: ctl.slot_upd = 1'b1;
      anac_pkg::ST_REST: begin
        ctl.rest_step = 1'b1;
        ctl.k_clr = sts.k_last && sts.rest_ok;
      end
      anac_pkg::ST_ATX: begin
        ctl.div_sel = anac_pkg::DV_TX;
        ctl.div_start = div_go && !sts.slot_empty;
        // skip an empty slot, its average counts as zero
        ctl.avg_next = sts.slot_empty && !sts.k_last;
      end
      anac_pkg::ST_ATY: begin
        ctl.div_sel = anac_pkg::DV_TY;
        ctl.div_start = div_go;
        ctl.avg_next = sts.div_done && !sts.k_last;
      end
      anac_pkg::ST_CX: begin
        ctl.div_sel = anac_pkg::DV_AX;
        ctl.div_start = div_go;
      end
      anac_pkg::ST_CY: begin
        ctl.div_sel = anac_pkg::DV_AY;
        ctl.div_start = div_go;
      end
      anac_pkg::ST_SQ: ctl.sq_ld = 1'b1;
      anac_pkg::ST_MOVE: ctl.move = 1'b1;
      anac_pkg::ST_OUT: ctl.out_ld = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hdl/anac_dp.sv =====
`timescale 1ns / 1ps
module anac_dp #(
  parameter int HISTORY_DEPTH = anac_pkg::HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [32:0]        cfg_data,
  input  logic signed [15:0] in_sample_x,
  input  logic signed [15:0] in_sample_y,
  input  logic [31:0]        in_now_ms,
  input  anac_pkg::ctl_t     ctl,
  output anac_pkg::sts_t     sts,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [8:0]  out_report_x,
  output logic signed [8:0]  out_report_y
);

  localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  logic [15:0]        interval_r;
  logic [32:0]        tol_r;
  logic signed [31:0] sum_x_r, sum_y_r, ax_r, ay_r;
  logic [15:0]        cnt_r;
  logic signed [15:0] last_x_r, last_y_r, center_x_r, center_y_r;
  logic [31:0]        now_r, last_check_r;
  logic [IW-1:0]      cur_r, k_r, ncur_r;
  logic               rest_r;
  logic signed [8:0]  rx_r, ry_r;
  logic [32:0]        sqx_r, sqy_r;
  logic               out_valid_r;
  logic signed [8:0]  out_x_r, out_y_r;

  logic signed [15:0] pos_x_r [HISTORY_DEPTH];
  logic signed [15:0] pos_y_r [HISTORY_DEPTH];
  logic [32:0]        dist_r [HISTORY_DEPTH];
  logic signed [31:0] tot_x_r [HISTORY_DEPTH];
  logic signed [31:0] tot_y_r [HISTORY_DEPTH];
  logic [15:0]        scnt_r [HISTORY_DEPTH];

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] s,
                                                 input logic signed [16:0] d);
    logic signed [32:0] t;
    t = 33'(s) + 33'(d);
    if (t > 33'sd2147483647) return 32'sh7FFFFFFF;
    else if (t < -33'sd2147483648) return 32'sh80000000;
    else return t[31:0];
  endfunction

  // shared divider
  logic signed [31:0] dv_a, dv_q;
  logic [15:0]        dv_b;
  logic               dv_busy, dv_done;

  always_comb begin
    unique case (ctl.div_sel)
      anac_pkg::DV_SX: begin dv_a = sum_x_r; dv_b = cnt_r; end
      anac_pkg::DV_SY: begin dv_a = sum_y_r; dv_b = cnt_r; end
      anac_pkg::DV_TX: begin dv_a = tot_x_r[k_r]; dv_b = scnt_r[k_r]; end
      anac_pkg::DV_TY: begin dv_a = tot_y_r[k_r]; dv_b = scnt_r[k_r]; end
      anac_pkg::DV_AX: begin dv_a = ax_r; dv_b = 16'(HISTORY_DEPTH); end
      anac_pkg::DV_AY: begin dv_a = ay_r; dv_b = 16'(HISTORY_DEPTH); end
      default: begin dv_a = sum_x_r; dv_b = cnt_r; end
    endcase
  end

  anac_div u_div (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start), .dividend(dv_a),
    .divisor(dv_b), .busy(dv_busy), .done(dv_done), .quotient(dv_q)
  );

  logic [31:0]        limit;
  logic signed [16:0] dx, dy;
  logic               k_last;

  assign limit  = last_check_r + 32'(interval_r);
  assign k_last = (k_r == IW'(HISTORY_DEPTH - 1));
  assign dx = 17'(pos_x_r[k_r]) - 17'(last_x_r);
  assign dy = 17'(pos_y_r[k_r]) - 17'(last_y_r);

  always_comb begin
    sts.cnt_zero   = (cnt_r == 16'd0);
    sts.div_busy   = dv_busy;
    sts.div_done   = dv_done;
    sts.advance    = (now_r > limit);
    sts.k_last     = k_last;
    sts.slot_empty = (scnt_r[k_r] == 16'd0);
    sts.rest_ok    = rest_r && (dist_r[k_r] < tol_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= anac_pkg::CHECK_INTERVAL_RST;
      tol_r      <= anac_pkg::REST_TOL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        anac_pkg::CFG_CHECK_INTERVAL: interval_r <= cfg_data[15:0];
        anac_pkg::CFG_REST_TOL: tol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= '0; sum_y_r <= '0; cnt_r <= '0;
      last_x_r <= '0; last_y_r <= '0;
      center_x_r <= '0; center_y_r <= '0;
      cur_r <= '0; k_r <= '0; ncur_r <= '0;
      last_check_r <= '0;
      rest_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        pos_x_r[i] <= '0; pos_y_r[i] <= '0; dist_r[i] <= '0;
        tot_x_r[i] <= '0; tot_y_r[i] <= '0; scnt_r[i] <= '0;
      end
    end else begin
      if (ctl.sample_ld) begin
        if (cnt_r != 16'hFFFF) begin
          sum_x_r <= sat_add(sum_x_r, 17'(in_sample_x) - 17'(center_x_r));
          sum_y_r <= sat_add(sum_y_r, 17'(in_sample_y) - 17'(center_y_r));
          cnt_r   <= cnt_r + 16'd1;
        end
        last_x_r <= in_sample_x;
        last_y_r <= in_sample_y;
      end

      if (ctl.report_ld) begin
        now_r <= in_now_ms;
        rx_r  <= '0;
        ry_r  <= '0;
      end

      if (dv_done) begin
        unique case (ctl.div_sel)
          anac_pkg::DV_SX: rx_r <= anac_pkg::to_report(dv_q);
          anac_pkg::DV_SY: ry_r <= anac_pkg::to_report(dv_q);
          anac_pkg::DV_TX: ax_r <= ax_r + dv_q;
          anac_pkg::DV_TY: ay_r <= ay_r + dv_q;
          anac_pkg::DV_AX: center_x_r <= dv_q[15:0];
          anac_pkg::DV_AY: center_y_r <= dv_q[15:0];
          default: ;
        endcase
      end

      if (ctl.slot_upd) begin
        sum_x_r <= '0;
        sum_y_r <= '0;
        cnt_r   <= '0;
        if (scnt_r[k_r] != 16'hFFFF) begin
          tot_x_r[k_r] <= tot_x_r[k_r] + 32'(last_x_r);
          tot_y_r[k_r] <= tot_y_r[k_r] + 32'(last_y_r);
          scnt_r[k_r]  <= scnt_r[k_r] + 16'd1;
        end
        if (sts.advance) begin
          last_check_r <= now_r;
          ncur_r <= k_last ? '0 : k_r + 1'b1;
          rest_r <= 1'b1;
          ax_r   <= '0;
          ay_r   <= '0;
        end
      end

      if (ctl.rest_step) rest_r <= sts.rest_ok;

      // one slot pointer serves every array access
      priority if (ctl.report_ld) k_r <= cur_r;
      else if (ctl.slot_upd && sts.advance && k_last) k_r <= '0;
      else if (ctl.k_clr) k_r <= '0;
      else if (ctl.rest_step && !k_last) k_r <= k_r + 1'b1;
      else if (ctl.avg_next) k_r <= k_r + 1'b1;
      else if (ctl.sq_ld) k_r <= ncur_r;

      if (ctl.sq_ld) begin
        sqx_r <= 33'(dx * dx);
        sqy_r <= 33'(dy * dy);
      end

      if (ctl.move) begin
        pos_x_r[k_r] <= last_x_r;
        pos_y_r[k_r] <= last_y_r;
        dist_r[k_r]  <= sqx_r + sqy_r;
        tot_x_r[k_r] <= '0;
        tot_y_r[k_r] <= '0;
        scnt_r[k_r]  <= '0;
        cur_r        <= k_r;
      end

      if (ctl.out_ld) begin
        out_valid_r <= 1'b1;
        out_x_r     <= rx_r;
        out_y_r     <= ry_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_report_x = out_x_r;
  assign out_report_y = out_y_r;

endmodule
